FILE: design/pal_pkg.sv
// Package for the positional array list: operation and status codes,
// default sizes and the command struct that the control hands to each cell.
// No dependencies.
package pal_pkg;

  // Fixed widths of the stream fields.
  localparam int MODE_W   = 3;
  localparam int INDEX_W  = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Packed stream words, rounded up to whole bytes.
  localparam int IN_DATA_W  = ((INDEX_W + VALUE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((VALUE_W + COUNT_W + 1 + 7) / 8) * 8;

  // Defaults for the top level parameters.
  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [MODE_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_READ   = 3'd3,
    OP_WRITE  = 3'd4,
    OP_CLEAR  = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // Broadcast command for the cell row. At most one flag is set.
  typedef struct packed {
    logic ins;   // open a slot at the position, cells above take their lower neighbor
    logic rem;   // cells at and above the position take their upper neighbor
    logic load;  // the cell at the position takes the new value
  } pal_cmd_t;

endpackage : pal_pkg

FILE: design/pal_cell.sv
// One storage cell of the positional array list. It holds one entry and
// updates from its neighbors or the broadcast value. Depends on pal_pkg.
module pal_cell import pal_pkg::*; #(
  parameter int DW       = DATA_WIDTH_DEF,
  parameter int CW       = 7,
  parameter int CELL_IDX = 0
) (
  input  logic          clk_i,
  input  pal_cmd_t      cmd_i,
  input  logic [CW-1:0] pos_i,
  input  logic [DW-1:0] value_i,
  input  logic [DW-1:0] prev_i,
  input  logic [DW-1:0] next_i,
  output logic [DW-1:0] data_o
);

  localparam logic [CW-1:0] MyIdx = CW'(CELL_IDX);

  logic [DW-1:0] data_q;
  logic [DW-1:0] data_d;
  logic          at_pos;
  logic          above_pos;

  assign at_pos    = (pos_i == MyIdx);
  assign above_pos = (pos_i < MyIdx);

  always_comb begin
    data_d = data_q;
    priority if (cmd_i.ins && above_pos) begin
      data_d = prev_i;
    end else if ((cmd_i.ins || cmd_i.load) && at_pos) begin
      data_d = value_i;
    end else if (cmd_i.rem && (at_pos || above_pos)) begin
      data_d = next_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule : pal_cell

FILE: design/positional_array_list_top.sv
// Top level of the positional array list: request decode, entry count,
// the row of storage cells and the registered result stage.
// Depends on pal_pkg and pal_cell.

// The block keeps an ordered list of up to DEPTH entries in a row of cells,
// one entry per cell, and serves one request per input word: append, insert
// at an index, remove at an index, read, write or clear. Insert and remove
// move every later entry by one place at once, since each cell loads from
// its neighbor in parallel; so the block accepts one word per clock while
// the result side keeps up. The result word is held in an output register,
// so a new request is taken in the same cycle that the previous result
// leaves. Each request gives one result word with the read data (zero
// unless a read succeeds), a status (ok, bad index or mode, list full), the
// entry count after the request and an empty flag. A bad index, an unused
// mode, or an append or insert on a full list leaves the list untouched.
// After reset the list is empty; storage holds no reset value, and only
// entries below the count can ever be read.
module positional_array_list_top import pal_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Request stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata from bit 0: index [6:0], value [38:7], zero fill [39].
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: mode [2:0].
  input  logic [MODE_W-1:0]     s_axis_tuser,
  // Result stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata from bit 0: read_value [31:0], count [38:32], empty_res [39].
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: status [1:0].
  output logic [STATUS_W-1:0]   m_axis_tuser
);

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMP_W = (CW > INDEX_W) ? CW : INDEX_W;
  localparam logic [CW-1:0] Full = CW'(DEPTH);

  // Request fields.
  logic [INDEX_W-1:0]    req_index;
  logic [VALUE_W-1:0]    req_value;
  logic [DATA_WIDTH-1:0] req_data;
  logic [CMP_W-1:0]      idx_cmp;
  logic [CMP_W-1:0]      cnt_cmp;
  logic                  idx_lt_cnt;
  logic                  idx_le_cnt;
  logic                  is_full;
  logic                  accept;

  assign req_index  = s_axis_tdata[INDEX_W-1:0];
  assign req_value  = s_axis_tdata[INDEX_W +: VALUE_W];
  assign req_data   = DATA_WIDTH'(req_value);
  assign accept     = s_axis_tvalid && s_axis_tready;

  // Entry count.
  logic [CW-1:0] count_q;
  logic [CW-1:0] count_d;

  assign idx_cmp    = CMP_W'(req_index);
  assign cnt_cmp    = CMP_W'(count_q);
  assign idx_lt_cnt = (idx_cmp < cnt_cmp);
  assign idx_le_cnt = (idx_cmp <= cnt_cmp);
  assign is_full    = (count_q == Full);

  // Decode. The command only reaches the cells on an accepted word.
  pal_cmd_t      cmd;
  pal_cmd_t      cmd_go;
  logic [CW-1:0] pos;
  logic          rd_ok;
  status_e       status;

  always_comb begin
    cmd     = '0;
    pos     = CW'(req_index);
    rd_ok   = 1'b0;
    status  = ST_OK;
    count_d = count_q;
    unique case (op_e'(s_axis_tuser))
      OP_APPEND: begin
        pos = count_q;
        if (is_full) begin
          status = ST_FULL;
        end else begin
          cmd.load = 1'b1;
          count_d  = count_q + CW'(1);
        end
      end
      OP_INSERT: begin
        if (!idx_le_cnt) begin
          status = ST_BAD;
        end else if (is_full) begin
          status = ST_FULL;
        end else begin
          cmd.ins = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (!idx_lt_cnt) begin
          status = ST_BAD;
        end else begin
          cmd.rem = 1'b1;
          count_d = count_q - CW'(1);
        end
      end
      OP_READ: begin
        if (!idx_lt_cnt) begin
          status = ST_BAD;
        end else begin
          rd_ok = 1'b1;
        end
      end
      OP_WRITE: begin
        if (!idx_lt_cnt) begin
          status = ST_BAD;
        end else begin
          cmd.load = 1'b1;
        end
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
        status = ST_BAD;
      end
    endcase
  end

  assign cmd_go = accept ? cmd : '0;

  // Row of cells. The ends of the row see zero from their missing neighbor;
  // those words land only in slots beyond the count.
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_w;
    logic [DATA_WIDTH-1:0] next_w;

    if (g == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid_lo
      assign prev_w = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_mid_hi
      assign next_w = cell_data[g+1];
    end

    pal_cell #(
      .DW      (DATA_WIDTH),
      .CW      (CW),
      .CELL_IDX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd_go),
      .pos_i  (pos),
      .value_i(req_data),
      .prev_i (prev_w),
      .next_i (next_w),
      .data_o (cell_data[g])
    );
  end

  // Read select: each cell gates its word by its own position match and the
  // row is OR-combined.
  logic [DATA_WIDTH-1:0] rd_data;

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (pos == CW'(i)) begin
        rd_data = rd_data | cell_data[i];
      end
    end
  end

  // Result register. A new word is taken whenever the slot is empty or is
  // being emptied in the same cycle.
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [STATUS_W-1:0]   out_user_q;
  logic [VALUE_W-1:0]    rd_word;

  assign rd_word       = rd_ok ? VALUE_W'(rd_data) : '0;
  assign s_axis_tready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
        count_q     <= count_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= OUT_DATA_W'({(count_d == '0), COUNT_W'(count_d), rd_word});
      out_user_q <= status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTHESIS
  // The count never passes the capacity of the cell row.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("entry count above capacity");

  // The cells never get more than one kind of update at once.
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_go))
    else $error("conflicting cell commands");

  // An accepted clear leaves an empty list.
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (s_axis_tuser == OP_CLEAR) |=> (count_q == '0))
    else $error("clear did not empty the list");

  // A successful insert grows the list by exactly one entry.
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_go.ins |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow the count by one");

  // A pending full status means the list is still at capacity.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_user_q == ST_FULL) |-> (count_q == Full))
    else $error("full status with list below capacity");
`endif

endmodule : positional_array_list_top
